/* src/modified_utf8_to_utf8_macros.svh */
// Assertion helpers shared by the converter.
`ifndef MODIFIED_UTF8_TO_UTF8_MACROS_SVH
`define MODIFIED_UTF8_TO_UTF8_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MU8_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("modified_utf8_to_utf8: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MU8_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("modified_utf8_to_utf8: next-cycle check failed");

`endif

/* src/mu8_pkg.sv */
package mu8_pkg;

  localparam int MaxResults = 4;
  localparam int HeldDepth  = 5;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [1:0] ST_DATA     = 2'd0;
  localparam logic [1:0] ST_OK       = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;
  localparam logic [1:0] ST_BAD_LEAD = 2'd3;

  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_CONT  = 8'h80;
  localparam logic [7:0] BYTE_C0    = 8'hC0;
  localparam logic [7:0] BYTE_E0    = 8'hE0;
  localparam logic [7:0] BYTE_F0    = 8'hF0;
  localparam logic [7:0] BYTE_ED    = 8'hED;
  localparam logic [7:0] BYTE_A0    = 8'hA0;
  localparam logic [7:0] BYTE_B0    = 8'hB0;

  typedef struct packed {
    logic [HeldDepth-1:0][7:0] held;
    logic [2:0]                cnt;
    logic [1:0]                err;
  } conv_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic [2:0]                  n;
    result_t [MaxResults-1:0]    res;
  } bundle_t;

endpackage

/* src/mu8_conv.sv */
module mu8_conv
  import mu8_pkg::*;
(
  input  logic        op_i,
  input  logic [7:0]  byte_i,
  input  conv_state_t state_i,
  output conv_state_t state_o,
  output bundle_t     bundle_o
);

  logic [7:0] h0, h1, h2, h4;
  logic       lead_two, lead_three, lead_ok, in_ascii, in_lead, hs_lead;
  logic [4:0] plane;
  logic [1:0] end_status;

  assign h0 = state_i.held[0];
  assign h1 = state_i.held[1];
  assign h2 = state_i.held[2];
  assign h4 = state_i.held[4];

  assign lead_two   = (h0 & BYTE_E0) == BYTE_C0;
  assign lead_three = (h0 & BYTE_F0) == BYTE_E0;
  assign lead_ok    = lead_two || lead_three;
  assign in_ascii   = (byte_i & BYTE_CONT) == 8'h00;
  assign in_lead    = ((byte_i & BYTE_E0) == BYTE_C0) || ((byte_i & BYTE_F0) == BYTE_E0);
  assign hs_lead    = (h0 == BYTE_ED) && ((h1 & BYTE_F0) == BYTE_A0);

  // Supplementary plane number: high surrogate field plus one.
  assign plane = 5'(h1[3:0]) + 5'd1;

  always_comb begin
    if (state_i.err != ST_DATA) begin
      end_status = state_i.err;
    end else if (state_i.cnt != 3'd0) begin
      end_status = ST_TRUNC;
    end else begin
      end_status = ST_OK;
    end
  end

  always_comb begin
    logic [2:0] n;
    result_t [MaxResults-1:0] res;
    n       = 3'd0;
    res     = '0;
    state_o = state_i;
    if (op_i == OP_BYTE) begin
      if (state_i.err == ST_DATA) begin
        if (state_i.cnt == 3'd0) begin
          if (in_ascii) begin
            res[0].out_byte = byte_i;
            n = 3'd1;
          end else if (in_lead) begin
            state_o.held[0] = byte_i;
            state_o.cnt     = 3'd1;
          end else begin
            state_o.err = ST_BAD_LEAD;
          end
        end else if (lead_two) begin
          if (h0 == BYTE_C0 && byte_i == BYTE_CONT) begin
            res[0].out_byte = BYTE_NUL;
            n = 3'd1;
          end else begin
            res[0].out_byte = h0;
            res[1].out_byte = byte_i;
            n = 3'd2;
          end
          state_o.cnt = 3'd0;
        end else begin
          case (state_i.cnt)
            3'd1: begin
              state_o.held[1] = byte_i;
              state_o.cnt     = 3'd2;
            end
            3'd2: begin
              state_o.held[2] = byte_i;
              if (hs_lead) begin
                state_o.cnt = 3'd3;
              end else begin
                res[0].out_byte = h0;
                res[1].out_byte = h1;
                res[2].out_byte = byte_i;
                n = 3'd3;
                state_o.cnt = 3'd0;
              end
            end
            3'd3: begin
              state_o.held[3] = byte_i;
              if (byte_i == BYTE_ED) begin
                state_o.cnt = 3'd4;
              end else begin
                // Lone high surrogate: flush it, then treat this byte as a fresh one.
                res[0].out_byte = h0;
                res[1].out_byte = h1;
                res[2].out_byte = h2;
                n = 3'd3;
                state_o.cnt = 3'd0;
                if (in_ascii) begin
                  res[3].out_byte = byte_i;
                  n = 3'd4;
                end else if (in_lead) begin
                  state_o.held[0] = byte_i;
                  state_o.cnt     = 3'd1;
                end else begin
                  state_o.err = ST_BAD_LEAD;
                end
              end
            end
            3'd4: begin
              state_o.held[4] = byte_i;
              if ((byte_i & BYTE_F0) == BYTE_B0) begin
                state_o.cnt = 3'd5;
              end else begin
                // Flush the high surrogate; the replayed ED starts a new
                // three-byte sequence with this byte as its second byte.
                res[0].out_byte = h0;
                res[1].out_byte = h1;
                res[2].out_byte = h2;
                n = 3'd3;
                state_o.held[0] = BYTE_ED;
                state_o.held[1] = byte_i;
                state_o.cnt     = 3'd2;
              end
            end
            default: begin
              res[0].out_byte = BYTE_F0 | 8'(plane[4:2]);
              res[1].out_byte = BYTE_CONT | {2'b00, plane[1:0], h2[5:2]};
              res[2].out_byte = BYTE_CONT | {2'b00, h2[1:0], h4[3:0]};
              res[3].out_byte = BYTE_CONT | {2'b00, byte_i[5:0]};
              n = 3'd4;
              state_o.cnt = 3'd0;
            end
          endcase
        end
      end
    end else begin
      if (state_i.err == ST_DATA && state_i.cnt >= 3'd3 && lead_ok && !lead_two) begin
        res[0].out_byte = h0;
        res[1].out_byte = h1;
        res[2].out_byte = h2;
        // A replayed ED leaves a sequence open, so the string is truncated.
        res[3].status   = (state_i.cnt >= 3'd4) ? ST_TRUNC : ST_OK;
        n = 3'd4;
      end else begin
        res[0].status = end_status;
        n = 3'd1;
      end
      state_o.cnt = 3'd0;
      state_o.err = ST_DATA;
    end
    for (int k = 0; k < MaxResults; k++) begin
      res[k].run_last = (3'(k) + 3'd1 == n);
    end
    bundle_o.n   = n;
    bundle_o.res = res;
  end

endmodule

/* src/modified_utf8_to_utf8.sv */
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   op_i, data_byte_i
// output    out        out_valid_o / out_stall_i out_byte_o, status_o, run_last_o
//
// An item is converted from the input register once the queue has room for its
// results, which are registered into the queue and shown from its head.
// One item is taken per cycle while the result queue has room for four results;
// the queue drains one result per cycle unless the output stalls, which bounds the output rate.
// Reset empties the input register and the queue and starts a new string.
// A stall on the output holds items back only once the queue has no room for four more results.
`include "modified_utf8_to_utf8_macros.svh"

module modified_utf8_to_utf8
  import mu8_pkg::*;
#(
  parameter int QueueDepth = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       run_last_o
);

  localparam int CntW = $clog2(QueueDepth + 1);

  logic        in_valid_q;
  logic        op_q;
  logic [7:0]  byte_q;
  logic        in_accept;
  logic        advance;

  conv_state_t state_q, state_d;
  bundle_t     bundle;

  result_t [QueueDepth-1:0] q_q, q_d, shifted;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     pop;
  logic [CntW-1:0]          push_n;
  logic [CntW-1:0]          base;

  mu8_conv u_conv (
    .op_i     (op_q),
    .byte_i   (byte_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .bundle_o (bundle)
  );

  // The register holding an item advances only when the queue can take its
  // largest burst of results.
  assign advance    = in_valid_q && (cnt_q <= CntW'(QueueDepth - MaxResults));
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign out_valid_o = cnt_q != '0;
  assign out_byte_o  = q_q[0].out_byte;
  assign status_o    = q_q[0].status;
  assign run_last_o  = q_q[0].run_last;

  assign pop    = out_valid_o && !out_stall_i;
  assign push_n = advance ? CntW'(bundle.n) : '0;
  assign base   = cnt_q - CntW'(pop);
  assign cnt_d  = base + push_n;

  always_comb begin
    for (int i = 0; i < QueueDepth - 1; i++) begin
      shifted[i] = q_q[i+1];
    end
    shifted[QueueDepth-1] = q_q[QueueDepth-1];
  end

  always_comb begin
    int off;
    for (int i = 0; i < QueueDepth; i++) begin
      off = i - int'(base);
      if (i < int'(base)) begin
        q_d[i] = pop ? shifted[i] : q_q[i];
      end else if (off < int'(push_n)) begin
        q_d[i] = bundle.res[off[1:0]];
      end else begin
        q_d[i] = q_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cnt_q      <= '0;
      state_q    <= '0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      cnt_q <= cnt_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= op_i;
      byte_q <= data_byte_i;
    end
    q_q <= q_d;
  end

  `MU8_ASSERT_NOW(a_queue_bound, 1'b1, cnt_q <= CntW'(QueueDepth))
  `MU8_ASSERT_NOW(a_held_bound, 1'b1, state_q.cnt <= 3'd5)
  `MU8_ASSERT_NOW(a_error_empty, state_q.err != ST_DATA, state_q.cnt == 3'd0)
  `MU8_ASSERT_NEXT(a_end_clears, advance && op_q == OP_END,
                   state_q.cnt == 3'd0 && state_q.err == ST_DATA)

endmodule

/* tb/sv/tb_modified_utf8_to_utf8.sv */
`timescale 1ns / 100ps

module tb_modified_utf8_to_utf8;
  import mu8_pkg::*;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam int StringItems = 42;
  localparam int HoldCycles  = 48;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       typed;     // expectation written into the row below
    logic       has_res;   // typed row gives one result, else none
    logic [7:0] t_byte;
    logic [1:0] t_status;
  } stim_row_t;

  localparam int DirRows = 28;
  localparam stim_row_t DirTable [DirRows] = '{
    '{OP_BYTE, 8'h00, 1'b1, 1'b1, 8'h00, ST_DATA},
    '{OP_BYTE, 8'h7F, 1'b1, 1'b1, 8'h7F, ST_DATA},
    '{OP_BYTE, 8'hC0, 1'b1, 1'b0, 8'h00, ST_DATA},
    '{OP_BYTE, 8'h80, 1'b1, 1'b1, 8'h00, ST_DATA},
    '{OP_BYTE, 8'hC3, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{OP_BYTE, 8'hFF, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{OP_END,  8'hFF, 1'b1, 1'b1, 8'h00, ST_OK},
    '{OP_BYTE, 8'hED, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{OP_BYTE, 8'hA0, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{OP_BYTE, 8'h80, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{OP_BYTE, 8'hED, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{OP_BYTE, 8'hB0, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{OP_BYTE, 8'h80, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{OP_BYTE, 8'hED, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{OP_BYTE, 8'hAF, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{OP_BYTE, 8'hBF, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{OP_BYTE, 8'h41, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{OP_BYTE, 8'hED, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{OP_BYTE, 8'hA5, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{OP_BYTE, 8'h81, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{OP_END,  8'h00, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{OP_BYTE, 8'hE2, 1'b1, 1'b0, 8'h00, ST_DATA},
    '{OP_END,  8'h00, 1'b1, 1'b1, 8'h00, ST_TRUNC},
    '{OP_BYTE, 8'h80, 1'b1, 1'b0, 8'h00, ST_DATA},
    '{OP_BYTE, 8'h41, 1'b1, 1'b0, 8'h00, ST_DATA},
    '{OP_END,  8'h00, 1'b1, 1'b1, 8'h00, ST_BAD_LEAD},
    '{OP_BYTE, 8'hFF, 1'b1, 1'b0, 8'h00, ST_DATA},
    '{OP_END,  8'h00, 1'b1, 1'b1, 8'h00, ST_BAD_LEAD}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       op_i;
  logic [7:0] data_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic [1:0] status_o;
  logic       run_last_o;

  stim_row_t cur_row;

  int unsigned tx_idle_pct = 26;
  int unsigned rx_idle_pct = 73;
  int          hold_left   = 0;

  int n_fail     = 0;
  int n_items    = 0;
  int n_results  = 0;
  int n_strings  = 0;
  int n_bad_strs = 0;
  int n_sent     = 0;

  // Converter state as seen by the prediction.
  logic [7:0]  held_q [HeldDepth];
  int unsigned held_n  = 0;
  logic [1:0]  str_err = ERR_NONE;
  result_t     step_res [$];
  logic [7:0]  replay_q [$];
  result_t     utf8_expected [$];

  modified_utf8_to_utf8 DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .run_last_o  (run_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d results still expected", $time, utf8_expected.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic void add_result(input logic [7:0] b, input logic [1:0] st);
    result_t r;
    if (step_res.size() < MaxResults) begin
      r.out_byte = b;
      r.status   = st;
      r.run_last = 1'b0;
      step_res.insert(step_res.size(), r);
    end
  endfunction

  // Copy out a held high surrogate; whatever was held after it is fed again.
  function automatic void flush_surrogate();
    for (int i = 3; i < held_n; i++) replay_q.insert(replay_q.size(), held_q[i]);
    add_result(held_q[0], ST_DATA);
    add_result(held_q[1], ST_DATA);
    add_result(held_q[2], ST_DATA);
    held_n = 0;
  endfunction

  function automatic void convert_byte(input logic [7:0] b);
    logic [7:0]  lead;
    logic [31:0] cp;
    lead = held_q[0];
    if (str_err != ERR_NONE) return;
    if (held_n == 0) begin
      if (b[7] == 1'b0) begin
        add_result(b, ST_DATA);
      end else if ((b & BYTE_E0) == BYTE_C0 || (b & BYTE_F0) == BYTE_E0) begin
        held_q[0] = b;
        held_n = 1;
      end else begin
        str_err = ST_BAD_LEAD;
      end
    end else if ((lead & BYTE_E0) == BYTE_C0) begin
      if (lead == BYTE_C0 && b == BYTE_CONT) begin
        add_result(BYTE_NUL, ST_DATA);
      end else begin
        add_result(lead, ST_DATA);
        add_result(b, ST_DATA);
      end
      held_n = 0;
    end else begin
      case (held_n)
        1: begin
          held_q[1] = b;
          held_n = 2;
        end
        2: begin
          held_q[2] = b;
          if (lead == BYTE_ED && (held_q[1] & BYTE_F0) == BYTE_A0) begin
            held_n = 3;
          end else begin
            add_result(lead, ST_DATA);
            add_result(held_q[1], ST_DATA);
            add_result(b, ST_DATA);
            held_n = 0;
          end
        end
        3: begin
          held_q[3] = b;
          held_n = 4;
          if (b != BYTE_ED) flush_surrogate();
        end
        4: begin
          held_q[4] = b;
          held_n = 5;
          if ((b & BYTE_F0) != BYTE_B0) flush_surrogate();
        end
        default: begin
          cp = ((32'(held_q[1][3:0]) + 32'd1) << 16) | (32'(held_q[2][5:0]) << 10)
             | (32'(held_q[4][3:0]) << 6) | 32'(b[5:0]);
          add_result(BYTE_F0 + 8'(cp[20:18]), ST_DATA);
          add_result(BYTE_CONT + 8'(cp[17:12]), ST_DATA);
          add_result(BYTE_CONT + 8'(cp[11:6]), ST_DATA);
          add_result(BYTE_CONT + 8'(cp[5:0]), ST_DATA);
          held_n = 0;
        end
      endcase
    end
  endfunction

  function automatic void convert_item(input logic op, input logic [7:0] b);
    logic [1:0] st;
    step_res.delete();
    replay_q.delete();
    if (op == OP_BYTE) begin
      convert_byte(b);
    end else if (str_err == ERR_NONE && held_n >= 3 && (held_q[0] & BYTE_F0) == BYTE_E0) begin
      flush_surrogate();
    end
    while (replay_q.size() != 0) convert_byte(replay_q.pop_front());
    if (op == OP_END) begin
      if (str_err != ERR_NONE) st = str_err;
      else if (held_n != 0) st = ST_TRUNC;
      else st = ST_OK;
      add_result(BYTE_NUL, st);
      held_n  = 0;
      str_err = ERR_NONE;
    end
    if (step_res.size() != 0) step_res[step_res.size() - 1].run_last = 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
      n_fail++;
    end
  endfunction

  // Prediction on accepted items, checking on accepted results.
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        convert_item(op_i, data_byte_i);
        if (cur_row.typed) begin
          if (cur_row.has_res) begin
            want.out_byte = cur_row.t_byte;
            want.status   = cur_row.t_status;
            want.run_last = 1'b1;
            utf8_expected.insert(utf8_expected.size(), want);
          end
        end else begin
          foreach (step_res[k]) utf8_expected.insert(utf8_expected.size(), step_res[k]);
        end
        n_items++;
      end
      if (out_valid_o && !out_stall_i) begin
        got.out_byte = out_byte_o;
        got.status   = status_o;
        got.run_last = run_last_o;
        n_results++;
        if (got.status != ST_DATA) n_strings++;
        if (got.status == ST_TRUNC || got.status == ST_BAD_LEAD) n_bad_strs++;
        if (utf8_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, got byte %0h status %0d last %0b",
                   $time, got.out_byte, got.status, got.run_last);
          n_fail++;
        end else begin
          want = utf8_expected.pop_front();
          check_field("out_byte", want.out_byte, got.out_byte);
          check_field("status", 8'(want.status), 8'(got.status));
          check_field("run_last", 8'(want.run_last), 8'(got.run_last));
        end
      end
    end
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  task automatic send_row(input stim_row_t row);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= row.op;
    data_byte_i <= row.data;
    cur_row     <= row;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_byte(input logic [7:0] b);
    stim_row_t row;
    row = '{OP_BYTE, b, 1'b0, 1'b0, BYTE_NUL, ST_DATA};
    send_row(row);
    n_sent++;
  endtask

  // One string of random characters, mostly well formed, closed by an end item.
  task automatic send_string();
    logic [7:0] seq [$];
    logic [7:0] pair [6];
    stim_row_t  row;
    int         nchar;
    int         cut;
    nchar = $urandom_range(0, 5);
    repeat (nchar) begin
      case ($urandom_range(0, 11))
        0, 1, 2: seq.insert(seq.size(), 8'($urandom_range(0, 127)));
        3: begin
          seq.insert(seq.size(), BYTE_C0);
          seq.insert(seq.size(), BYTE_CONT);
        end
        4: begin
          seq.insert(seq.size(), 8'($urandom_range(8'hC0, 8'hDF)));
          seq.insert(seq.size(), 8'($urandom_range(0, 255)));
        end
        5, 6: begin
          seq.insert(seq.size(), ($urandom_range(0, 3) == 0) ?
                     BYTE_ED : 8'($urandom_range(8'hE0, 8'hEF)));
          seq.insert(seq.size(), 8'($urandom_range(8'h80, 8'hBF)));
          seq.insert(seq.size(), 8'($urandom_range(8'h80, 8'hBF)));
        end
        7, 8, 9: begin
          seq.insert(seq.size(), BYTE_ED);
          seq.insert(seq.size(), 8'($urandom_range(8'hA0, 8'hAF)));
          seq.insert(seq.size(), 8'($urandom_range(8'h80, 8'hBF)));
          seq.insert(seq.size(), BYTE_ED);
          seq.insert(seq.size(), 8'($urandom_range(8'hB0, 8'hBF)));
          seq.insert(seq.size(), 8'($urandom_range(8'h80, 8'hBF)));
        end
        10: begin
          // A high surrogate with no partner; the next character follows it.
          seq.insert(seq.size(), BYTE_ED);
          seq.insert(seq.size(), 8'($urandom_range(8'hA0, 8'hAF)));
          seq.insert(seq.size(), 8'($urandom_range(8'h80, 8'hBF)));
        end
        default: seq.insert(seq.size(), 8'($urandom_range(0, 255)));
      endcase
    end
    // Now and then the string stops in the middle of a sequence.
    if ($urandom_range(0, 5) == 0) begin
      pair[0] = BYTE_ED;
      pair[1] = 8'($urandom_range(8'hA0, 8'hAF));
      pair[2] = 8'($urandom_range(8'h80, 8'hBF));
      pair[3] = BYTE_ED;
      pair[4] = 8'($urandom_range(8'hB0, 8'hBF));
      pair[5] = 8'($urandom_range(8'h80, 8'hBF));
      if ($urandom_range(0, 2) == 0) pair[0] = 8'($urandom_range(8'hC0, 8'hEF));
      cut = $urandom_range(1, 5);
      for (int i = 0; i < cut; i++) seq.insert(seq.size(), pair[i]);
    end
    foreach (seq[k]) send_byte(seq[k]);
    row = '{OP_END, 8'($urandom_range(0, 255)), 1'b0, 1'b0, BYTE_NUL, ST_DATA};
    send_row(row);
    n_sent++;
  endtask

  initial begin
    in_valid_i  <= 1'b0;
    op_i        <= OP_BYTE;
    data_byte_i <= BYTE_NUL;
    cur_row     <= '0;
    foreach (held_q[i]) held_q[i] = BYTE_NUL;
    @(posedge rst_ni);
    @(posedge clk_i);

    foreach (DirTable[i]) send_row(DirTable[i]);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 26;
          rx_idle_pct = 73;
        end
        1: begin
          tx_idle_pct = 73;
          rx_idle_pct = 26;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          // The output holds off while items keep coming, so the block backs up.
          hold_left = HoldCycles;
        end
      endcase
      n_sent = 0;
      while (n_sent < StringItems) send_string();
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (utf8_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Converted %0d input items into %0d checked results.", n_items, n_results);
    $display("Closed %0d strings, %0d of them reported truncated or with a bad lead byte.",
             n_strings, n_bad_strs);
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/mu8_pkg.sv
src/mu8_conv.sv
src/modified_utf8_to_utf8.sv
tb/sv/tb_modified_utf8_to_utf8.sv
